FILE: rtl/core/sfd_pkg.sv
// Shared types and constants for the sensor frame deframer.
package sfd_pkg;

  localparam int MAX_PAYLOAD = 12;
  localparam int PIDX_W      = $clog2(MAX_PAYLOAD);
  localparam int IDX_W       = 5;
  localparam int PADDR_W     = 3;

  localparam logic [7:0]  START_BYTE_RST = 8'h01;
  localparam logic [15:0] TYPE_PHASE     = 16'h0A13;
  localparam logic [15:0] TYPE_BREATH    = 16'h0A14;
  localparam logic [15:0] TYPE_HEART     = 16'h0A15;
  localparam logic [15:0] TYPE_DIST      = 16'h0A16;
  localparam logic [IDX_W-1:0] LEN_PHASE = IDX_W'(12);
  localparam logic [IDX_W-1:0] LEN_RATE  = IDX_W'(4);
  localparam logic [IDX_W-1:0] LEN_DIST  = IDX_W'(8);
  localparam logic [IDX_W-1:0] HDR_LAST  = IDX_W'(7);

  localparam logic [0:0] REG_START_BYTE = 1'b0;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HDR_CSUM  = 3'd1,
    ST_DATA_CSUM = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_NO_TARGET = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_PHASE  = 2'd0,
    KIND_BREATH = 2'd1,
    KIND_HEART  = 2'd2,
    KIND_DIST   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [15:0] frame_type;
    logic [15:0] frame_ident;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
  } out_item_t;

  // Payload length for a header type; zero marks an unknown type.
  function automatic logic [IDX_W-1:0] type_len(input logic [15:0] t);
    case (t)
      TYPE_PHASE:  type_len = LEN_PHASE;
      TYPE_BREATH: type_len = LEN_RATE;
      TYPE_HEART:  type_len = LEN_RATE;
      TYPE_DIST:   type_len = LEN_DIST;
      default:     type_len = '0;
    endcase
  endfunction

  function automatic kind_t type_kind(input logic [15:0] t);
    case (t)
      TYPE_BREATH: type_kind = KIND_BREATH;
      TYPE_HEART:  type_kind = KIND_HEART;
      TYPE_DIST:   type_kind = KIND_DIST;
      default:     type_kind = KIND_PHASE;
    endcase
  endfunction

endpackage

FILE: rtl/core/sensor_frame_deframer.sv
// Top level of the sensor frame deframer: config register, parser, output skid.
//
// The block takes one transaction per received serial byte on the in_ channel
// (op = byte or receive timeout) and returns one transaction per complete frame
// on the out_ channel: status, kind, raw type and id, and up to three
// little-endian payload words. A frame is the start byte, seven more header
// bytes ending in an inverted-XOR checksum, then a payload and its checksum.
// An input transaction is taken every cycle while in_stall is low; its result,
// if any, is formed by the parser and registered into the output register, or
// into the skid register while the output is held by out_stall.
// When the receiver stalls, a second result is parked in a one-entry skid
// register and in_stall rises until the skid entry moves into the output
// register.
// Reset (rst_n low at a clock edge) returns the parser to hunting, empties the
// output and skid registers and sets start_byte to 0x01.
// start_byte sits at byte address 0 of the APB port; write it only while no
// frame is in flight.
module sensor_frame_deframer import sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] start_byte_r;
  logic       in_acc;
  logic       res_valid;
  out_item_t  res;
  logic       out_take;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  out_item_t  skid_data_r, skid_data_nxt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_BYTE) ? {24'h0, start_byte_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_START_BYTE) begin
      start_byte_r <= pwdata[7:0];
    end
  end

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  sfd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (in_acc),
    .item       (in_data),
    .start_byte (start_byte_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_valid_r && skid_valid_nxt |-> out_valid_r && out_stall && res_valid)
    else $error("skid register filled without a stalled output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result produced while the skid register is full");

endmodule

FILE: rtl/core/sfd_parse.sv
// Frame parser: per-byte state update, payload store and result formation.
module sfd_parse import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  in_item_t   item,
  input  logic [7:0] start_byte,
  output logic       res_valid,
  output out_item_t  res
);

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       hxor_r, hxor_nxt;
  logic [7:0]       dxor_r, dxor_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [15:0]      ident_r, ident_nxt;
  logic             hgood_r, hgood_nxt;
  logic [7:0]       store_r [MAX_PAYLOAD];
  logic             store_we;

  logic [IDX_W-1:0] plen;
  kind_t            kind;
  logic             hdr_ok;
  logic [31:0]      w0, w4, w8;

  assign plen   = type_len(type_r);
  assign kind   = type_kind(type_r);
  assign hdr_ok = (~hxor_r) == item.rx_byte;

  function automatic logic [7:0] byte_at(input int i);
    byte_at = (i < MAX_PAYLOAD) ? store_r[i] : 8'h00;
  endfunction

  always_comb begin
    w0 = {byte_at(3), byte_at(2), byte_at(1), byte_at(0)};
    w4 = {byte_at(7), byte_at(6), byte_at(5), byte_at(4)};
    w8 = {byte_at(11), byte_at(10), byte_at(9), byte_at(8)};
  end

  // Next-state logic.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    hxor_nxt  = hxor_r;
    dxor_nxt  = dxor_r;
    type_nxt  = type_r;
    ident_nxt = ident_r;
    hgood_nxt = hgood_r;
    store_we  = 1'b0;
    if (en) begin
      if (item.op == OP_TIMEOUT) begin
        phase_nxt = PH_HUNT;
        idx_nxt   = '0;
        hxor_nxt  = '0;
        dxor_nxt  = '0;
        hgood_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_HEAD: begin
            if (idx_r < HDR_LAST) begin
              hxor_nxt = hxor_r ^ item.rx_byte;
              idx_nxt  = idx_r + IDX_W'(1);
              case (idx_r)
                IDX_W'(1): ident_nxt = {item.rx_byte, 8'h00};
                IDX_W'(2): ident_nxt = {ident_r[15:8], item.rx_byte};
                IDX_W'(5): type_nxt  = {item.rx_byte, 8'h00};
                IDX_W'(6): type_nxt  = {type_r[15:8], item.rx_byte};
                default: ;
              endcase
            end else if (plen == '0) begin
              phase_nxt = PH_HUNT;
              idx_nxt   = '0;
              hxor_nxt  = '0;
              dxor_nxt  = '0;
              hgood_nxt = 1'b0;
            end else begin
              phase_nxt = PH_DATA;
              idx_nxt   = '0;
              dxor_nxt  = '0;
              hgood_nxt = hdr_ok;
            end
          end
          PH_DATA: begin
            if (idx_r < plen) begin
              store_we = idx_r < IDX_W'(MAX_PAYLOAD);
              dxor_nxt = dxor_r ^ item.rx_byte;
              idx_nxt  = idx_r + IDX_W'(1);
            end else begin
              phase_nxt = PH_HUNT;
              idx_nxt   = '0;
              hxor_nxt  = '0;
              dxor_nxt  = '0;
              hgood_nxt = 1'b0;
            end
          end
          default: begin
            if (item.rx_byte == start_byte) begin
              phase_nxt = PH_HEAD;
              idx_nxt   = IDX_W'(1);
              hxor_nxt  = item.rx_byte;
              type_nxt  = '0;
              ident_nxt = '0;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  // Result logic: a result leaves on the header checksum byte of an unknown
  // type or on the data checksum byte of a known one.
  always_comb begin
    res_valid       = 1'b0;
    res.status      = ST_OK;
    res.kind        = kind;
    res.frame_type  = type_r;
    res.frame_ident = ident_r;
    res.word_a      = '0;
    res.word_b      = '0;
    res.word_c      = '0;
    if (en && item.op == OP_BYTE) begin
      case (phase_r)
        PH_HEAD: begin
          if (idx_r >= HDR_LAST && plen == '0) begin
            res_valid  = 1'b1;
            res.status = hdr_ok ? ST_UNKNOWN : ST_HDR_CSUM;
            res.kind   = KIND_PHASE;
          end
        end
        PH_DATA: begin
          if (idx_r >= plen) begin
            res_valid = 1'b1;
            if (!hgood_r) begin
              res.status = ST_HDR_CSUM;
            end else if ((~dxor_r) != item.rx_byte) begin
              res.status = ST_DATA_CSUM;
            end else if (kind == KIND_PHASE) begin
              res.word_a = w0;
              res.word_b = w4;
              res.word_c = w8;
            end else if (kind == KIND_DIST) begin
              if (w0 != 32'd1) begin
                res.status = ST_NO_TARGET;
              end else begin
                res.word_a = w4;
              end
            end else begin
              res.word_a = w0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
      hxor_r  <= '0;
      dxor_r  <= '0;
      type_r  <= '0;
      ident_r <= '0;
      hgood_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      hxor_r  <= hxor_nxt;
      dxor_r  <= dxor_nxt;
      type_r  <= type_nxt;
      ident_r <= ident_nxt;
      hgood_r <= hgood_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r[PIDX_W-1:0]] <= item.rx_byte;
    end
  end

  a_hunt_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT |-> idx_r == '0 && !hgood_r)
    else $error("index or header flag left set while hunting");

  a_head_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEAD |-> idx_r >= IDX_W'(1) && idx_r <= HDR_LAST)
    else $error("header byte index out of range");

  a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> plen != '0 && idx_r <= plen)
    else $error("payload index beyond type length");

endmodule

FILE: verif/sensor_frame_deframer_test.sv
// Self-checking testbench for the sensor frame deframer with its own frame predictor.
`timescale 1ns / 100ps

module sensor_frame_deframer_test;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    FLAW_NONE,
    FLAW_HDR,
    FLAW_DATA,
    FLAW_CUT,
    FLAW_NO_TARGET
  } flaw_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Pending byte transactions and the frame results they are predicted to produce.
  in_item_t  byte_queue[$];
  out_item_t expected_frames[$];

  // Predictor state.
  logic [7:0]  start_now = START_BYTE_RST;
  phase_t      rx_phase;
  int          rx_idx;
  logic [7:0]  hdr_xor;
  logic [7:0]  dat_xor;
  logic [15:0] type_hold;
  logic [15:0] ident_hold;
  logic        hdr_ok;
  logic [7:0]  pay_bytes[MAX_PAYLOAD];

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   accepted = 0;
  int   frames_checked = 0;
  int   stim_items = 0;
  int   status_seen[8];

  sensor_frame_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Payload length of a header type, zero for an unknown type.
  function automatic int frame_len(input logic [15:0] t, output kind_t k);
    k = KIND_PHASE;
    case (t)
      TYPE_PHASE:  frame_len = int'(LEN_PHASE);
      TYPE_BREATH: begin
        k = KIND_BREATH;
        frame_len = int'(LEN_RATE);
      end
      TYPE_HEART:  begin
        k = KIND_HEART;
        frame_len = int'(LEN_RATE);
      end
      TYPE_DIST:   begin
        k = KIND_DIST;
        frame_len = int'(LEN_DIST);
      end
      default:     frame_len = 0;
    endcase
  endfunction

  function automatic logic [31:0] le_word(input int base);
    logic [31:0] w;
    w = '0;
    for (int j = 3; j >= 0; j--)
      w = {w[23:0], (base + j < MAX_PAYLOAD) ? pay_bytes[base + j] : 8'h00};
    return w;
  endfunction

  task automatic drop_frame();
    rx_phase = PH_HUNT;
    rx_idx   = 0;
    hdr_xor  = '0;
    dat_xor  = '0;
    hdr_ok   = 1'b0;
  endtask

  task automatic emit_frame(input out_item_t r);
    r.frame_type  = type_hold;
    r.frame_ident = ident_hold;
    expected_frames.push_back(r);
  endtask

  task automatic predict_item(input in_item_t it);
    logic [7:0] b;
    kind_t      k;
    int         plen;
    out_item_t  r;
    b = it.rx_byte;
    r = '0;
    if (it.op == OP_TIMEOUT) begin
      drop_frame();
    end else if (rx_phase == PH_HEAD && rx_idx < int'(HDR_LAST)) begin
      hdr_xor ^= b;
      case (rx_idx)
        1: ident_hold[15:8] = b;
        2: ident_hold[7:0]  = b;
        5: type_hold[15:8]  = b;
        6: type_hold[7:0]   = b;
        default: ;
      endcase
      rx_idx++;
    end else if (rx_phase == PH_HEAD) begin
      hdr_ok = ((hdr_xor ^ b) == 8'hFF);
      plen = frame_len(type_hold, k);
      if (plen == 0) begin
        // Unknown type ends the frame right at the header checksum.
        r.status = hdr_ok ? ST_UNKNOWN : ST_HDR_CSUM;
        r.kind   = KIND_PHASE;
        emit_frame(r);
        drop_frame();
      end else begin
        rx_phase = PH_DATA;
        rx_idx   = 0;
        dat_xor  = '0;
      end
    end else if (rx_phase == PH_DATA) begin
      plen = frame_len(type_hold, k);
      if (rx_idx < plen) begin
        if (rx_idx < MAX_PAYLOAD) pay_bytes[rx_idx] = b;
        dat_xor ^= b;
        rx_idx++;
      end else begin
        r.kind = k;
        if (!hdr_ok) begin
          r.status = ST_HDR_CSUM;
        end else if ((dat_xor ^ b) != 8'hFF) begin
          r.status = ST_DATA_CSUM;
        end else if (k == KIND_DIST) begin
          if (le_word(0) != 32'd1) begin
            r.status = ST_NO_TARGET;
          end else begin
            r.status = ST_OK;
            r.word_a = le_word(4);
          end
        end else begin
          r.status = ST_OK;
          r.word_a = le_word(0);
          if (k == KIND_PHASE) begin
            r.word_b = le_word(4);
            r.word_c = le_word(8);
          end
        end
        emit_frame(r);
        drop_frame();
      end
    end else if (b == start_now) begin
      rx_phase   = PH_HEAD;
      rx_idx     = 1;
      hdr_xor    = b;
      type_hold  = '0;
      ident_hold = '0;
    end else begin
      rx_phase = PH_HUNT;
    end
  endtask

  // Sender: a held transaction stays on the bus until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() != 0 && (quiet || $urandom_range(99) >= 12)) begin
          in_valid <= 1'b1;
          in_data  <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 12);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("frame_type", 32'(want.frame_type), 32'(out_data.frame_type));
        check_field("frame_ident", 32'(want.frame_ident), 32'(out_data.frame_ident));
        check_field("word_a", want.word_a, out_data.word_a);
        check_field("word_b", want.word_b, out_data.word_b);
        check_field("word_c", want.word_c, out_data.word_c);
        frames_checked++;
        status_seen[want.status]++;
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_frames.size() != 0);
  endtask

  task automatic write_start(input logic [7:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_START_BYTE, 2'b00});
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    start_now = v;
  endtask

  // Bytes that do not open a frame; with resync any value may appear and a
  // receive timeout follows to drop whatever partial frame they started.
  task automatic queue_noise(input int n, input bit resync);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (!resync && b == start_now);
      byte_queue.push_back(in_item_t'{OP_BYTE, b});
    end
    if (resync) byte_queue.push_back(in_item_t'{OP_TIMEOUT, 8'($urandom)});
  endtask

  task automatic queue_frame(input logic [15:0] ident, input logic [15:0] ftype,
                             input flaw_t flaw);
    logic [7:0]  bytes[$];
    logic [7:0]  x;
    logic [15:0] len;
    logic [31:0] flag;
    kind_t       k;
    int          plen;
    int          n;
    plen = frame_len(ftype, k);
    len  = 16'($urandom);
    bytes = '{start_now, ident[15:8], ident[7:0], len[15:8], len[7:0],
              ftype[15:8], ftype[7:0]};
    x = 8'h00;
    foreach (bytes[i]) x ^= bytes[i];
    bytes.push_back(~x ^ ((flaw == FLAW_HDR) ? 8'($urandom_range(1, 255)) : 8'h00));
    if (plen > 0) begin
      for (int i = 0; i < plen; i++) bytes.push_back(8'($urandom));
      if (k == KIND_DIST) begin
        flag = 32'd1;
        if (flaw == FLAW_NO_TARGET) begin
          // Either a big-endian one or any other value.
          flag = $urandom_range(1) ? 32'h0100_0000 : $urandom;
          if (flag == 32'd1) flag = 32'd0;
        end
        for (int i = 0; i < 4; i++) bytes[8 + i] = flag[8*i +: 8];
      end
      x = 8'h00;
      for (int i = 8; i < 8 + plen; i++) x ^= bytes[i];
      bytes.push_back(~x ^ ((flaw == FLAW_DATA) ? 8'($urandom_range(1, 255)) : 8'h00));
    end
    n = bytes.size();
    if (flaw == FLAW_CUT) n = $urandom_range(1, bytes.size() - 1);
    for (int i = 0; i < n; i++) byte_queue.push_back(in_item_t'{OP_BYTE, bytes[i]});
    if (flaw == FLAW_CUT) byte_queue.push_back(in_item_t'{OP_TIMEOUT, 8'($urandom)});
    stim_items += n;
  endtask

  task automatic queue_random_traffic(input int target);
    int          stop;
    int          pick;
    logic [15:0] ftype;
    flaw_t       flaw;
    stop = stim_items + target;
    while (stim_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 22)      ftype = TYPE_PHASE;
      else if (pick < 42) ftype = TYPE_BREATH;
      else if (pick < 62) ftype = TYPE_HEART;
      else if (pick < 88) ftype = TYPE_DIST;
      else                ftype = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 68)      flaw = FLAW_NONE;
      else if (pick < 76) flaw = FLAW_HDR;
      else if (pick < 84) flaw = FLAW_DATA;
      else if (pick < 92) flaw = FLAW_CUT;
      else                flaw = FLAW_NO_TARGET;
      if ($urandom_range(99) < 25)
        queue_noise($urandom_range(1, 4), $urandom_range(2) == 0);
      queue_frame(16'($urandom), ftype, flaw);
    end
  endtask

  initial begin
    logic [7:0] settings[6];
    settings = '{START_BYTE_RST, 8'h00, 8'hFF, 8'hA5, 8'($urandom), START_BYTE_RST};
    drop_frame();
    type_hold  = '0;
    ident_hold = '0;
    foreach (pay_bytes[i]) pay_bytes[i] = 8'h00;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int s = 0; s < 6; s++) begin
      if (s > 0) begin
        wait_drained();
        // The last byte of a frame that produced nothing may still be in the parser.
        repeat (4) @(posedge clk);
        write_start(settings[s]);
      end
      quiet <= (s == 2);
      if (s == 3) hold_req <= 1'b1;
      if (s == 0) begin
        byte_queue.push_back(in_item_t'{OP_TIMEOUT, 8'hFF});
        queue_noise(3, 1'b0);
        queue_frame(16'h0000, TYPE_PHASE, FLAW_NONE);
        queue_frame(16'hFFFF, TYPE_BREATH, FLAW_NONE);
        queue_frame(16'h1234, TYPE_HEART, FLAW_NONE);
        queue_frame(16'h8001, TYPE_DIST, FLAW_NONE);
        queue_frame(16'h00FF, TYPE_DIST, FLAW_NO_TARGET);
        queue_frame(16'hFF00, TYPE_PHASE, FLAW_HDR);
        queue_frame(16'($urandom), 16'hFFFF, FLAW_NONE);
        queue_frame(16'($urandom), 16'h0000, FLAW_HDR);
        queue_frame(16'($urandom), TYPE_BREATH, FLAW_DATA);
        queue_frame(16'($urandom), TYPE_DIST, FLAW_CUT);
      end
      queue_random_traffic(40);
      // Let everything drain before the second half of this setting.
      wait_drained();
      queue_random_traffic(40);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_frames.size());
      mismatches++;
    end
    $display("Checked %0d frame results from %0d accepted transactions over 6 start bytes.",
             frames_checked, accepted);
    $display("Status mix: ok %0d, header csum %0d, data csum %0d, unknown %0d, no target %0d.",
             status_seen[ST_OK], status_seen[ST_HDR_CSUM], status_seen[ST_DATA_CSUM],
             status_seen[ST_UNKNOWN], status_seen[ST_NO_TARGET]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_parse.sv
rtl/core/sensor_frame_deframer.sv
verif/sensor_frame_deframer_test.sv
